/* rtl/frr_pkg.sv */
// Shared types and constants of the frame receiver and router.
package frr_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_SRC  = 5'b00010,
        PH_DST  = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_PAY  = 5'b10000
    } phase_t;

    localparam logic [2:0] CFG_PORT_ROLE  = 3'd0;
    localparam logic [2:0] CFG_IDLE_LIMIT = 3'd1;
    localparam logic [2:0] CFG_OWN_ADDR   = 3'd2;
    localparam logic [2:0] CFG_DOWN_ADDR  = 3'd3;
    localparam logic [2:0] CFG_HOST_ADDR  = 3'd4;
    localparam logic [2:0] CFG_HIGH_ADDR  = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] STATUS_COMPLETE = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    localparam logic [2:0] TYPE_DATA       = 3'd1;
    localparam logic [2:0] TYPE_STATUS_REQ = 3'd3;

    localparam logic [2:0] ROUTE_DROP         = 3'd0;
    localparam logic [2:0] ROUTE_LOCAL        = 3'd1;
    localparam logic [2:0] ROUTE_STATUS_REPLY = 3'd2;
    localparam logic [2:0] ROUTE_DOWNSTREAM   = 3'd3;
    localparam logic [2:0] ROUTE_HOST         = 3'd4;

    localparam logic ROLE_HOST_FACING = 1'b0;

    typedef struct packed {
        logic       result_kind;
        logic [1:0] frame_status;
        logic [2:0] frame_type;
        logic [7:0] source;
        logic [7:0] destination;
        logic [7:0] payload_length;
        logic [2:0] route;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
    } result_t;

endpackage

/* rtl/frame_receiver_router.sv */
// Top level of the frame receiver and router: header parsing, routing and result queue.
//
// Usage: each input transfer carries either a received byte (opcode 0) or one
// elapsed time tick (opcode 1). The block hunts for a type byte, collects
// source, destination and length, checks the header and passes payload bytes
// out with their index. At frame end it gives a report with the header and a
// route; an idle gap inside a frame gives a timeout report instead.
// Configuration registers are written through the cfg channel, which is
// always ready; writes are meant to arrive only while the block is idle.
// One input transfer is accepted per cycle while in_stall is low; its results are
// registered into a four-entry result queue, at most two per item, and the queue
// is drained at one transfer per cycle while out_stall is low, so the queue
// occupancy sets the input rate.
// When the receiver stalls, results wait in the queue and in_stall rises once
// fewer than two free entries remain. Reset clears the queue, the parse state
// and the configuration registers to their defaults.
module frame_receiver_router #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [1:0]  frame_status,
    output logic [2:0]  frame_type,
    output logic [7:0]  source,
    output logic [7:0]  destination,
    output logic [7:0]  payload_length,
    output logic [2:0]  route,
    output logic [7:0]  payload_byte,
    output logic [5:0]  payload_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TAKEN_W = $clog2(MAX_PAYLOAD + 1);

    logic        port_role_reg;
    logic [15:0] idle_limit_reg;
    logic [1:0]  own_address_reg;
    logic [1:0]  downstream_address_reg;
    logic [1:0]  host_address_reg;
    logic [7:0]  highest_address_reg;

    frr_pkg::phase_t     phase_reg, phase_next;
    logic [2:0]          held_type_reg, held_type_next;
    logic [7:0]          held_source_reg, held_source_next;
    logic [7:0]          held_destination_reg, held_destination_next;
    logic [7:0]          held_length_reg, held_length_next;
    logic [TAKEN_W-1:0]  bytes_taken_reg, bytes_taken_next;
    logic [15:0]         idle_ticks_reg, idle_ticks_next;

    frr_pkg::result_t                     fifo_reg [frr_pkg::FIFO_DEPTH];
    logic [frr_pkg::PTR_W-1:0]            wr_ptr_reg, rd_ptr_reg;
    logic [frr_pkg::CNT_W-1:0]            count_reg, count_next;

    frr_pkg::result_t res0, res1;
    logic [1:0]       push_n;
    logic             in_fire, out_fire;
    logic [15:0]      tick_count;
    logic [15:0]      limit;
    logic [8:0]       taken_inc;
    logic [2:0]       frame_route;

    function automatic frr_pkg::result_t make_result(
        input logic       kind,
        input logic [1:0] status,
        input logic [2:0] ftype,
        input logic [7:0] src,
        input logic [7:0] dst,
        input logic [7:0] len,
        input logic [2:0] rte,
        input logic [7:0] pbyte,
        input logic [5:0] pidx
    );
        frr_pkg::result_t r;
        r.result_kind    = kind;
        r.frame_status   = status;
        r.frame_type     = ftype;
        r.source         = src;
        r.destination    = dst;
        r.payload_length = len;
        r.route          = rte;
        r.payload_byte   = pbyte;
        r.payload_index  = pidx;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (count_reg > frr_pkg::CNT_W'(frr_pkg::FIFO_DEPTH - 2));
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && !out_stall;

    always_comb
    begin
        if (port_role_reg == frr_pkg::ROLE_HOST_FACING)
        begin
            if (held_destination_reg == {6'd0, own_address_reg})
            begin
                if (held_type_reg == frr_pkg::TYPE_STATUS_REQ)
                    frame_route = frr_pkg::ROUTE_STATUS_REPLY;
                else if (held_type_reg == frr_pkg::TYPE_DATA)
                    frame_route = frr_pkg::ROUTE_LOCAL;
                else
                    frame_route = frr_pkg::ROUTE_DROP;
            end
            else if (held_destination_reg == {6'd0, downstream_address_reg})
                frame_route = frr_pkg::ROUTE_DOWNSTREAM;
            else
                frame_route = frr_pkg::ROUTE_DROP;
        end
        else if (held_destination_reg == {6'd0, host_address_reg})
            frame_route = frr_pkg::ROUTE_HOST;
        else
            frame_route = frr_pkg::ROUTE_DROP;
    end

    always_comb
    begin
        phase_next            = phase_reg;
        held_type_next        = held_type_reg;
        held_source_next      = held_source_reg;
        held_destination_next = held_destination_reg;
        held_length_next      = held_length_reg;
        bytes_taken_next      = bytes_taken_reg;
        idle_ticks_next       = idle_ticks_reg;
        push_n                = 2'd0;
        tick_count            = (idle_ticks_reg == 16'hFFFF) ? idle_ticks_reg
                                                             : idle_ticks_reg + 16'd1;
        limit                 = (idle_limit_reg == 16'd0) ? 16'd1 : idle_limit_reg;
        taken_inc             = 9'(bytes_taken_reg) + 9'd1;
        res0 = make_result(frr_pkg::KIND_REPORT, frr_pkg::STATUS_TIMEOUT, held_type_reg,
                           held_source_reg, held_destination_reg, held_length_reg,
                           frr_pkg::ROUTE_DROP, 8'd0, 6'd0);
        res1 = make_result(frr_pkg::KIND_REPORT, frr_pkg::STATUS_COMPLETE, held_type_reg,
                           held_source_reg, held_destination_reg, held_length_reg,
                           frame_route, 8'd0, 6'd0);
        if (in_fire)
        begin
            if (opcode == frr_pkg::OP_TICK)
            begin
                if (phase_reg != frr_pkg::PH_HUNT)
                begin
                    idle_ticks_next = tick_count;
                    if (tick_count >= limit)
                    begin
                        push_n          = 2'd1;
                        phase_next      = frr_pkg::PH_HUNT;
                        idle_ticks_next = 16'd0;
                    end
                end
            end
            else
            begin
                idle_ticks_next = 16'd0;
                case (phase_reg)
                    frr_pkg::PH_HUNT:
                    begin
                        if (rx_byte inside {[8'd1:8'd4]})
                        begin
                            held_type_next        = rx_byte[2:0];
                            held_source_next      = 8'd0;
                            held_destination_next = 8'd0;
                            held_length_next      = 8'd0;
                            bytes_taken_next      = '0;
                            phase_next            = frr_pkg::PH_SRC;
                        end
                    end
                    frr_pkg::PH_SRC:
                    begin
                        held_source_next = rx_byte;
                        phase_next       = frr_pkg::PH_DST;
                    end
                    frr_pkg::PH_DST:
                    begin
                        held_destination_next = rx_byte;
                        phase_next            = frr_pkg::PH_LEN;
                    end
                    frr_pkg::PH_LEN:
                    begin
                        held_length_next = rx_byte;
                        bytes_taken_next = '0;
                        if (held_source_reg > highest_address_reg
                            || held_destination_reg > highest_address_reg
                            || 9'(rx_byte) > 9'(MAX_PAYLOAD))
                        begin
                            res0 = make_result(frr_pkg::KIND_REPORT, frr_pkg::STATUS_REJECTED,
                                               held_type_reg, held_source_reg,
                                               held_destination_reg, rx_byte,
                                               frr_pkg::ROUTE_DROP, 8'd0, 6'd0);
                            push_n     = 2'd1;
                            phase_next = frr_pkg::PH_HUNT;
                        end
                        else if (rx_byte == 8'd0)
                        begin
                            res0 = make_result(frr_pkg::KIND_REPORT, frr_pkg::STATUS_COMPLETE,
                                               held_type_reg, held_source_reg,
                                               held_destination_reg, rx_byte,
                                               frame_route, 8'd0, 6'd0);
                            push_n     = 2'd1;
                            phase_next = frr_pkg::PH_HUNT;
                        end
                        else
                            phase_next = frr_pkg::PH_PAY;
                    end
                    frr_pkg::PH_PAY:
                    begin
                        res0 = make_result(frr_pkg::KIND_PAYLOAD, frr_pkg::STATUS_COMPLETE,
                                           held_type_reg, held_source_reg,
                                           held_destination_reg, held_length_reg,
                                           frr_pkg::ROUTE_DROP, rx_byte,
                                           6'(bytes_taken_reg));
                        bytes_taken_next = TAKEN_W'(taken_inc);
                        if (taken_inc >= 9'(held_length_reg))
                        begin
                            push_n     = 2'd2;
                            phase_next = frr_pkg::PH_HUNT;
                        end
                        else
                            push_n = 2'd1;
                    end
                    default:
                        phase_next = frr_pkg::PH_HUNT;
                endcase
            end
        end
        count_next = count_reg + frr_pkg::CNT_W'(push_n)
                     - (out_fire ? frr_pkg::CNT_W'(1) : frr_pkg::CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_role_reg          <= 1'b0;
            idle_limit_reg         <= 16'd20;
            own_address_reg        <= 2'd1;
            downstream_address_reg <= 2'd2;
            host_address_reg       <= 2'd0;
            highest_address_reg    <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                frr_pkg::CFG_PORT_ROLE:  port_role_reg          <= cfg_data[0];
                frr_pkg::CFG_IDLE_LIMIT: idle_limit_reg         <= cfg_data;
                frr_pkg::CFG_OWN_ADDR:   own_address_reg        <= cfg_data[1:0];
                frr_pkg::CFG_DOWN_ADDR:  downstream_address_reg <= cfg_data[1:0];
                frr_pkg::CFG_HOST_ADDR:  host_address_reg       <= cfg_data[1:0];
                frr_pkg::CFG_HIGH_ADDR:  highest_address_reg    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= frr_pkg::PH_HUNT;
            held_type_reg        <= 3'd0;
            held_source_reg      <= 8'd0;
            held_destination_reg <= 8'd0;
            held_length_reg      <= 8'd0;
            bytes_taken_reg      <= '0;
            idle_ticks_reg       <= 16'd0;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
            count_reg            <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            held_type_reg        <= held_type_next;
            held_source_reg      <= held_source_next;
            held_destination_reg <= held_destination_next;
            held_length_reg      <= held_length_next;
            bytes_taken_reg      <= bytes_taken_next;
            idle_ticks_reg       <= idle_ticks_next;
            wr_ptr_reg           <= wr_ptr_reg + frr_pkg::PTR_W'(push_n);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + frr_pkg::PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + frr_pkg::PTR_W'(1)] <= res1;
    end

    assign result_kind    = fifo_reg[rd_ptr_reg].result_kind;
    assign frame_status   = fifo_reg[rd_ptr_reg].frame_status;
    assign frame_type     = fifo_reg[rd_ptr_reg].frame_type;
    assign source         = fifo_reg[rd_ptr_reg].source;
    assign destination    = fifo_reg[rd_ptr_reg].destination;
    assign payload_length = fifo_reg[rd_ptr_reg].payload_length;
    assign route          = fifo_reg[rd_ptr_reg].route;
    assign payload_byte   = fifo_reg[rd_ptr_reg].payload_byte;
    assign payload_index  = fifo_reg[rd_ptr_reg].payload_index;

    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= frr_pkg::CNT_W'(frr_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // While payload is being taken, the count stays below the header length.
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == frr_pkg::PH_PAY |-> 9'(bytes_taken_reg) < 9'(held_length_reg))
        else $error("payload count ran past the header length");

    // The idle count is always clear while hunting.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == frr_pkg::PH_HUNT |-> idle_ticks_reg == 16'd0)
        else $error("idle count not cleared in hunt");

    // A payload byte that ends a frame, with no result drained alongside it, leaves two more results in the queue.
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2 && !out_fire) |=> count_reg == $past(count_reg) + frr_pkg::CNT_W'(2))
        else $error("frame end report lost");

endmodule

/* dv/tb_frame_receiver_router.sv */
// Self-checking regression testbench for the frame receiver and router.
`timescale 1ns / 100ps

module tb_frame_receiver_router;

    localparam int PAYLOAD_LIMIT  = 64;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SETTLE_LIMIT   = 20000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 80;
    localparam int MAX_PRINTED    = 50;

    localparam logic [2:0] TYPE_ACK         = 3'd2;
    localparam logic [2:0] TYPE_STATUS_RESP = 3'd4;
    localparam logic [2:0] CFG_UNUSED_LO    = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI    = 3'd7;
    localparam logic       ROLE_DOWN_FACING = 1'b1;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = frr_pkg::OP_BYTE;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [1:0]  frame_status;
    logic [2:0]  frame_type;
    logic [7:0]  source;
    logic [7:0]  destination;
    logic [7:0]  payload_length;
    logic [2:0]  route;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = frr_pkg::CFG_PORT_ROLE;
    logic [15:0] cfg_data = 16'd0;

    // Parser model state and its copy of the configuration.
    frr_pkg::phase_t rx_phase = frr_pkg::PH_HUNT;
    logic [2:0]  frm_type = 3'd0;
    logic [7:0]  frm_src = 8'd0;
    logic [7:0]  frm_dst = 8'd0;
    logic [7:0]  frm_len = 8'd0;
    logic [6:0]  payload_count = 7'd0;
    logic [15:0] quiet_ticks = 16'd0;
    logic        role_cfg = frr_pkg::ROLE_HOST_FACING;
    logic [15:0] idle_limit_cfg = 16'd20;
    logic [1:0]  own_cfg = 2'd1;
    logic [1:0]  down_cfg = 2'd2;
    logic [1:0]  host_cfg = 2'd0;
    logic [7:0]  high_cfg = 8'd3;

    frr_pkg::result_t expected_results[$];
    int           error_count = 0;
    int           results_seen = 0;
    int           items_sent = 0;
    int           useful_items = 0;
    int           burst_left = 0;
    int           payload_results = 0;
    int           status_seen[0:2] = '{0, 0, 0};
    int           route_seen[0:4] = '{0, 0, 0, 0, 0};
    logic [15:0]  stall_clock = 16'd0;
    stall_style_t stall_style = STALL_NONE;

    frame_receiver_router #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .frame_status(frame_status),
        .frame_type(frame_type),
        .source(source),
        .destination(destination),
        .payload_length(payload_length),
        .route(route),
        .payload_byte(payload_byte),
        .payload_index(payload_index),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    function automatic int unsigned effective_limit();
        return (idle_limit_cfg == 16'd0) ? 32'd1 : {16'd0, idle_limit_cfg};
    endfunction

    function automatic logic [2:0] choose_route();
        if (role_cfg == frr_pkg::ROLE_HOST_FACING)
        begin
            if (frm_dst == {6'd0, own_cfg})
            begin
                if (frm_type == frr_pkg::TYPE_STATUS_REQ)
                    return frr_pkg::ROUTE_STATUS_REPLY;
                if (frm_type == frr_pkg::TYPE_DATA)
                    return frr_pkg::ROUTE_LOCAL;
                return frr_pkg::ROUTE_DROP;
            end
            if (frm_dst == {6'd0, down_cfg})
                return frr_pkg::ROUTE_DOWNSTREAM;
            return frr_pkg::ROUTE_DROP;
        end
        return (frm_dst == {6'd0, host_cfg}) ? frr_pkg::ROUTE_HOST : frr_pkg::ROUTE_DROP;
    endfunction

    function automatic frr_pkg::result_t frame_report(input logic [1:0] status,
                                                      input logic [2:0] rt);
        return {frr_pkg::KIND_REPORT, status, frm_type, frm_src, frm_dst, frm_len, rt,
                8'd0, 6'd0};
    endfunction

    // Advances the parser model by one input transfer and queues the results it gives.
    // Returns 0 when the transfer leaves the parser untouched.
    function automatic bit advance_parser(input logic op, input logic [7:0] b);
        if (op == frr_pkg::OP_TICK)
        begin
            if (rx_phase == frr_pkg::PH_HUNT)
                return 1'b0;
            if (quiet_ticks != 16'hFFFF)
                quiet_ticks++;
            if (quiet_ticks >= effective_limit())
            begin
                expected_results.push_back(frame_report(frr_pkg::STATUS_TIMEOUT,
                                                        frr_pkg::ROUTE_DROP));
                rx_phase = frr_pkg::PH_HUNT;
                quiet_ticks = 16'd0;
            end
            return 1'b1;
        end
        quiet_ticks = 16'd0;
        case (rx_phase)
            frr_pkg::PH_HUNT:
            begin
                if (!(b inside {[8'd1:8'd4]}))
                    return 1'b0;
                frm_type = b[2:0];
                frm_src = 8'd0;
                frm_dst = 8'd0;
                frm_len = 8'd0;
                payload_count = 7'd0;
                rx_phase = frr_pkg::PH_SRC;
            end
            frr_pkg::PH_SRC:
            begin
                frm_src = b;
                rx_phase = frr_pkg::PH_DST;
            end
            frr_pkg::PH_DST:
            begin
                frm_dst = b;
                rx_phase = frr_pkg::PH_LEN;
            end
            frr_pkg::PH_LEN:
            begin
                frm_len = b;
                payload_count = 7'd0;
                if (frm_src > high_cfg || frm_dst > high_cfg || frm_len > PAYLOAD_LIMIT)
                begin
                    expected_results.push_back(frame_report(frr_pkg::STATUS_REJECTED,
                                                            frr_pkg::ROUTE_DROP));
                    rx_phase = frr_pkg::PH_HUNT;
                end
                else if (frm_len == 8'd0)
                begin
                    expected_results.push_back(frame_report(frr_pkg::STATUS_COMPLETE,
                                                            choose_route()));
                    rx_phase = frr_pkg::PH_HUNT;
                end
                else
                    rx_phase = frr_pkg::PH_PAY;
            end
            frr_pkg::PH_PAY:
            begin
                expected_results.push_back({frr_pkg::KIND_PAYLOAD, frr_pkg::STATUS_COMPLETE,
                                            frm_type, frm_src, frm_dst, frm_len,
                                            frr_pkg::ROUTE_DROP, b, payload_count[5:0]});
                payload_count++;
                if (payload_count >= frm_len)
                begin
                    expected_results.push_back(frame_report(frr_pkg::STATUS_COMPLETE,
                                                            choose_route()));
                    rx_phase = frr_pkg::PH_HUNT;
                end
            end
            default:
                rx_phase = frr_pkg::PH_HUNT;
        endcase
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got_v,
                               input logic [7:0] want_v);
        if (got_v !== want_v)
            flag_error($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got_v, want_v));
    endtask

    // The sender works in bursts; a transfer completes when in_stall is low at the edge.
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(40, 120);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        opcode <= op;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        if (advance_parser(op, b))
            useful_items++;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
            expected_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            frr_pkg::CFG_PORT_ROLE:  role_cfg = value[0];
            frr_pkg::CFG_IDLE_LIMIT: idle_limit_cfg = value;
            frr_pkg::CFG_OWN_ADDR:   own_cfg = value[1:0];
            frr_pkg::CFG_DOWN_ADDR:  down_cfg = value[1:0];
            frr_pkg::CFG_HOST_ADDR:  host_cfg = value[1:0];
            frr_pkg::CFG_HIGH_ADDR:  high_cfg = value[7:0];
            default:                 ;
        endcase
    endtask

    // Unused upper data bits carry random values; the block must ignore them.
    task automatic set_config(input logic role, input logic [15:0] limit, input logic [1:0] own,
                              input logic [1:0] down, input logic [1:0] host,
                              input logic [7:0] high);
        logic [15:0] junk;
        junk = 16'($urandom);
        settle();
        write_reg(frr_pkg::CFG_PORT_ROLE, {junk[14:0], role});
        write_reg(frr_pkg::CFG_IDLE_LIMIT, limit);
        write_reg(frr_pkg::CFG_OWN_ADDR, {junk[13:0], own});
        write_reg(frr_pkg::CFG_DOWN_ADDR, {junk[15:2], down});
        write_reg(frr_pkg::CFG_HOST_ADDR, {junk[14:1], host});
        write_reg(frr_pkg::CFG_HIGH_ADDR, {junk[7:0], high});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic maybe_ticks(input bit enable);
        int unsigned lim;
        int unsigned top;
        int unsigned n;
        lim = effective_limit();
        if (enable && lim > 1 && $urandom_range(0, 4) == 0)
        begin
            top = (lim - 1 < 4) ? lim - 1 : 4;
            n = ($urandom_range(0, 3) == 0 && lim <= 64) ? lim - 1 : $urandom_range(1, top);
            repeat (n) send_item(frr_pkg::OP_TICK, any_byte());
        end
    endtask

    task automatic send_frame(input logic [2:0] ftype, input logic [7:0] src,
                              input logic [7:0] dst, input logic [7:0] len, input bit sprinkle);
        bit header_ok;
        header_ok = src <= high_cfg && dst <= high_cfg && len <= PAYLOAD_LIMIT;
        send_item(frr_pkg::OP_BYTE, {5'd0, ftype});
        maybe_ticks(sprinkle);
        send_item(frr_pkg::OP_BYTE, src);
        maybe_ticks(sprinkle);
        send_item(frr_pkg::OP_BYTE, dst);
        maybe_ticks(sprinkle);
        send_item(frr_pkg::OP_BYTE, len);
        if (header_ok)
        begin
            for (int i = 0; i < len; i++)
            begin
                maybe_ticks(sprinkle);
                send_item(frr_pkg::OP_BYTE, any_byte());
            end
        end
    endtask

    function automatic logic [7:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 8'($urandom_range(0, 3));
        if (r < 17)
            return 8'($urandom_range(0, high_cfg));
        return any_byte();
    endfunction

    function automatic logic [7:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return 8'($urandom_range(0, 6));
        if (r < 17)
            return 8'($urandom_range(7, 63));
        if (r < 18)
            return 8'(PAYLOAD_LIMIT);
        return 8'($urandom_range(PAYLOAD_LIMIT + 1, 255));
    endfunction

    task automatic test_hunt_and_header();
        send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, 8'h00);
        send_item(frr_pkg::OP_BYTE, 8'hFF);
        send_item(frr_pkg::OP_BYTE, 8'h05);
        send_frame(frr_pkg::TYPE_DATA, 8'd0, 8'd1, 8'd0, 1'b0);
        send_frame(frr_pkg::TYPE_STATUS_REQ, 8'd3, 8'd1, 8'd1, 1'b0);
        send_frame(TYPE_ACK, 8'd1, 8'd2, 8'd0, 1'b0);
        send_frame(TYPE_STATUS_RESP, 8'd1, 8'd1, 8'd0, 1'b0);
        send_frame(TYPE_STATUS_RESP, 8'd4, 8'd0, 8'd0, 1'b0);
        send_frame(frr_pkg::TYPE_DATA, 8'd0, 8'd255, 8'd2, 1'b0);
        send_frame(frr_pkg::TYPE_DATA, 8'd0, 8'd3, 8'd65, 1'b0);
    endtask

    task automatic test_max_payload();
        send_frame(frr_pkg::TYPE_DATA, 8'd2, 8'd1, 8'(PAYLOAD_LIMIT), 1'b0);
        send_frame(TYPE_ACK, 8'd0, 8'd2, 8'd255, 1'b0);
    endtask

    // A timeout is provoked in the source, length and payload phases; one tick fewer must not abort.
    task automatic test_idle_timeout();
        send_item(frr_pkg::OP_BYTE, {5'd0, frr_pkg::TYPE_DATA});
        repeat (19) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, 8'd0);
        repeat (19) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, 8'd1);
        repeat (20) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, {5'd0, frr_pkg::TYPE_STATUS_REQ});
        send_item(frr_pkg::OP_BYTE, 8'd1);
        send_item(frr_pkg::OP_BYTE, 8'd1);
        send_item(frr_pkg::OP_BYTE, 8'd2);
        send_item(frr_pkg::OP_BYTE, any_byte());
        repeat (20) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, {5'd0, TYPE_STATUS_RESP});
        repeat (20) send_item(frr_pkg::OP_TICK, any_byte());
    endtask

    task automatic route_sweep();
        for (int t = 1; t <= 4; t++)
        begin
            for (int d = 0; d <= 3; d++)
                send_frame(3'(t), 8'($urandom_range(0, 3)), 8'(d), 8'($urandom_range(0, 2)),
                           1'b0);
        end
    endtask

    task automatic test_routing();
        set_config(frr_pkg::ROLE_HOST_FACING, 16'd20, 2'd2, 2'd2, 2'd3, 8'd3);
        route_sweep();
        set_config(ROLE_DOWN_FACING, 16'd20, 2'd2, 2'd1, 2'd2, 8'd3);
        route_sweep();
        set_config(frr_pkg::ROLE_HOST_FACING, 16'd20, 2'd0, 2'd3, 2'd1, 8'd3);
        route_sweep();
        set_config(ROLE_DOWN_FACING, 16'd20, 2'd3, 2'd0, 2'd0, 8'd3);
        route_sweep();
    endtask

    task automatic test_config_extremes();
        set_config(ROLE_DOWN_FACING, 16'd0, 2'd3, 2'd3, 2'd3, 8'd0);
        send_item(frr_pkg::OP_BYTE, {5'd0, frr_pkg::TYPE_DATA});
        send_item(frr_pkg::OP_TICK, any_byte());
        send_frame(frr_pkg::TYPE_DATA, 8'd0, 8'd0, 8'd1, 1'b0);
        send_frame(TYPE_ACK, 8'd1, 8'd0, 8'd0, 1'b0);
        send_frame(frr_pkg::TYPE_STATUS_REQ, 8'd0, 8'd3, 8'd0, 1'b0);
        set_config(frr_pkg::ROLE_HOST_FACING, 16'd1, 2'd0, 2'd0, 2'd0, 8'd255);
        send_frame(frr_pkg::TYPE_DATA, 8'd255, 8'd0, 8'd2, 1'b0);
        send_frame(TYPE_ACK, 8'd255, 8'd255, 8'd3, 1'b0);
        send_item(frr_pkg::OP_BYTE, {5'd0, TYPE_ACK});
        send_item(frr_pkg::OP_BYTE, 8'd7);
        send_item(frr_pkg::OP_TICK, any_byte());
        // Only the top limit bit is set, so a long quiet spell must not abort the frame.
        set_config(frr_pkg::ROLE_HOST_FACING, 16'h8000, 2'd1, 2'd2, 2'd0, 8'd3);
        send_item(frr_pkg::OP_BYTE, {5'd0, frr_pkg::TYPE_DATA});
        repeat (40) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, 8'd2);
        repeat (40) send_item(frr_pkg::OP_TICK, any_byte());
        send_item(frr_pkg::OP_BYTE, 8'd1);
        send_item(frr_pkg::OP_BYTE, 8'd0);
        settle();
        write_reg(CFG_UNUSED_LO, {8'd0, any_byte()});
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_frame(frr_pkg::TYPE_DATA, 8'd0, 8'd1, 8'd1, 1'b0);
        send_frame(frr_pkg::TYPE_STATUS_REQ, 8'd3, 8'd2, 8'd0, 1'b0);
    endtask

    // Mostly well-formed frames with random content, the rest truncated frames and noise.
    // Halfway through each phase the sender waits for every outstanding result.
    task automatic test_random_traffic();
        int unsigned phase_start;
        int unsigned r;
        logic [7:0]  high;
        bit          paused;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            r = $urandom_range(0, 3);
            high = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? any_byte() : 8'd3;
            set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 40)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), high);
            phase_start = useful_items;
            paused = 1'b0;
            while (useful_items - phase_start < PHASE_ITEMS)
            begin
                if (!paused && useful_items - phase_start >= PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_frame(3'($urandom_range(1, 4)), pick_address(), pick_address(),
                               pick_length(), 1'b1);
                else if (r < 82)
                begin
                    send_item(frr_pkg::OP_BYTE, 8'($urandom_range(1, 4)));
                    repeat ($urandom_range(0, 5)) send_item(frr_pkg::OP_BYTE, pick_address());
                    repeat (effective_limit()) send_item(frr_pkg::OP_TICK, any_byte());
                end
                else if (r < 92)
                    repeat ($urandom_range(1, 3)) send_item(frr_pkg::OP_BYTE, any_byte());
                else
                    repeat ($urandom_range(1, 4)) send_item(frr_pkg::OP_TICK, any_byte());
            end
            repeat (effective_limit()) send_item(frr_pkg::OP_TICK, any_byte());
        end
    endtask

    always @(posedge clk)
    begin
        stall_clock <= stall_clock + 16'd1;
        if (stall_clock[7:0] == 8'd0)
            stall_style <= stall_style_t'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= stall_clock[2] & stall_clock[0];
        endcase
    end

    always @(posedge clk)
    begin
        frr_pkg::result_t got;
        frr_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {result_kind, frame_status, frame_type, source, destination, payload_length,
                   route, payload_byte, payload_index};
            results_seen++;
            if (expected_results.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing expected: %h",
                                     results_seen, got));
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", 8'(got.result_kind), 8'(want.result_kind));
                check_field("frame_status", 8'(got.frame_status), 8'(want.frame_status));
                check_field("frame_type", 8'(got.frame_type), 8'(want.frame_type));
                check_field("source", got.source, want.source);
                check_field("destination", got.destination, want.destination);
                check_field("payload_length", got.payload_length, want.payload_length);
                check_field("route", 8'(got.route), 8'(want.route));
                check_field("payload_byte", got.payload_byte, want.payload_byte);
                check_field("payload_index", 8'(got.payload_index), 8'(want.payload_index));
                if (want.result_kind == frr_pkg::KIND_PAYLOAD)
                    payload_results++;
                else
                begin
                    status_seen[want.frame_status]++;
                    route_seen[want.route]++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hunt_and_header();
        test_max_payload();
        test_idle_timeout();
        test_routing();
        test_config_extremes();
        test_random_traffic();
        settle();
        $display("Sent %0d input transfers (%0d acted on); checked %0d results, %0d payload.",
                 items_sent, useful_items, results_seen, payload_results);
        $display("Reports: %0d complete, %0d rejected, %0d timed out; routes %0d/%0d/%0d/%0d/%0d.",
                 status_seen[0], status_seen[1], status_seen[2], route_seen[0], route_seen[1],
                 route_seen[2], route_seen[3], route_seen[4]);
        if (error_count == 0)
            $display("frame_receiver_router regression: pass");
        else
            $display("frame_receiver_router regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run stopped by the watchdog with %0d results outstanding.",
                 expected_results.size());
        $display("frame_receiver_router regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/frr_pkg.sv
rtl/frame_receiver_router.sv
dv/tb_frame_receiver_router.sv
